// ----- design/usrd_pkg.sv -----
// Package for the USB setup request decoder: codes, configuration and command types.
// No dependencies; the front end, queue, back end and top level import it.
package usrd_pkg;

	typedef enum logic [1:0] {
		ACT_STALL  = 2'd0,
		ACT_STATUS = 2'd1,
		ACT_REPLY  = 2'd2,
		ACT_ACCEPT = 2'd3
	} action_t;

	// Reply sources.
	localparam logic [2:0] SRC_DEVICE      = 3'd0;
	localparam logic [2:0] SRC_CONFIG      = 3'd1;
	localparam logic [2:0] SRC_STRING0     = 3'd2;
	localparam logic [2:0] SRC_LINE_CODING = 3'd6;
	localparam logic [2:0] SRC_INLINE      = 3'd7;

	// Bit positions in the effects vector.
	localparam int FX_ADDRESS     = 0;
	localparam int FX_CONFIG      = 1;
	localparam int FX_LINE_STATE  = 2;
	localparam int FX_CLASS_RESET = 3;
	localparam int FX_HALT        = 4;
	localparam int FX_UNHALT      = 5;
	localparam int FX_WIDTH       = 6;

	// Request type field (bits 6-5 of bmRequestType).
	localparam logic [1:0] TYPE_STANDARD = 2'b00;
	localparam logic [1:0] TYPE_CLASS    = 2'b01;

	localparam logic [4:0] RCPT_DEVICE   = 5'h00;
	localparam logic [4:0] RCPT_ENDPOINT = 5'h02;

	// Standard request codes.
	localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
	localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
	localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
	localparam logic [7:0] REQ_GET_INTERFACE     = 8'h0A;
	localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0B;

	// Class request codes.
	localparam logic [7:0] REQ_CDC_SET_LINE_CODING  = 8'h20;
	localparam logic [7:0] REQ_CDC_GET_LINE_CODING  = 8'h21;
	localparam logic [7:0] REQ_CDC_SET_LINE_STATE   = 8'h22;
	localparam logic [7:0] REQ_MSC_GET_MAX_LUN      = 8'hFE;
	localparam logic [7:0] REQ_MSC_BULK_ONLY_RESET  = 8'hFF;

	// Descriptor types.
	localparam logic [7:0] DTYPE_DEVICE = 8'h01;
	localparam logic [7:0] DTYPE_CONFIG = 8'h02;
	localparam logic [7:0] DTYPE_STRING = 8'h03;

	// Device classes.
	localparam logic [1:0] CLASS_CDC = 2'd1;
	localparam logic [1:0] CLASS_MSC = 2'd2;

	localparam logic [15:0] DEVICE_DESC_LEN  = 16'd18;
	localparam logic [15:0] LINE_CODING_LEN  = 16'd7;
	localparam logic [15:0] LEN_NO_LIMIT     = 16'hFFFF;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_CLASS  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SELF_PWR      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_LENGTH = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRING_MASK   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRING0_LEN   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRING1_LEN   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRING2_LEN   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRING3_LEN   = 3'd7;

	localparam int NUM_STRINGS = 4;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  device_class;
		logic        self_pwr;
		logic [15:0] config_length;
		logic [NUM_STRINGS-1:0] string_valid_mask;
		logic [NUM_STRINGS-1:0][7:0] str_bytes;
	} cfg_t;

	// A classified request, ready for the back end to carry out.
	typedef struct packed {
		action_t     action;
		logic [2:0]  source;
		logic [15:0] avail;
		logic [15:0] asked;
		logic [7:0]  byte_zero;
		logic        byte_zero_from_conf;
		logic [FX_WIDTH-1:0] effects;
		logic [6:0]  device_address;
		logic [7:0]  configuration;
		logic        dtr;
		logic [7:0]  endpoint;
	} cmd_t;

endpackage

// ----- design/usrd_if.sv -----
// Channel interfaces of the USB setup request decoder: setup packets in, decisions out.
// Depends on nothing; the field widths follow the block's item definitions.
interface usrd_setup_if;
	logic        valid;
	logic        ready;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_index;
	logic [15:0] request_length;

	modport source(output valid, request_type, request_code, request_value, request_index,
		request_length, input ready);
	modport sink(input valid, request_type, request_code, request_value, request_index,
		request_length, output ready);
endinterface

interface usrd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  reply_source;
	logic [15:0] reply_length;
	logic [7:0]  reply_byte_zero;
	logic [7:0]  reply_byte_one;
	logic [5:0]  effects;
	logic [6:0]  device_address;
	logic [7:0]  configuration;
	logic        dtr;
	logic [7:0]  endpoint;

	modport source(output valid, action, reply_source, reply_length, reply_byte_zero,
		reply_byte_one, effects, device_address, configuration, dtr, endpoint, input ready);
	modport sink(input valid, action, reply_source, reply_length, reply_byte_zero,
		reply_byte_one, effects, device_address, configuration, dtr, endpoint, output ready);
endinterface

// ----- design/usrd_front.sv -----
// Front end: accepts setup packets and classifies each into a command for the queue.
// Depends on usrd_pkg and usrd_setup_if.
module usrd_front
	import usrd_pkg::*;
(
	input  cfg_t cfg,
	usrd_setup_if.sink req,
	input  logic full,
	output logic push,
	output cmd_t cmd
);

	logic       to_host;
	logic [1:0] req_kind;
	logic [4:0] recipient;
	logic [7:0] desc_type;
	logic [7:0] desc_index;
	logic       class_done;

	assign req.ready = !full;
	assign push      = req.valid && !full;

	assign to_host    = req.request_type[7];
	assign req_kind   = req.request_type[6:5];
	assign recipient  = req.request_type[4:0];
	assign desc_type  = req.request_value[15:8];
	assign desc_index = req.request_value[7:0];

	always_comb begin
		cmd        = '0;
		cmd.action = ACT_STALL;
		class_done = 1'b0;
		if (req_kind == TYPE_CLASS) begin
			if (cfg.device_class == CLASS_CDC) begin
				if (req.request_code == REQ_CDC_SET_LINE_STATE) begin
					cmd.dtr                    = req.request_value[0];
					cmd.effects[FX_LINE_STATE] = 1'b1;
					cmd.action                 = ACT_STATUS;
					class_done                 = 1'b1;
				end else if (req.request_code == REQ_CDC_SET_LINE_CODING) begin
					cmd.action = ACT_ACCEPT;
					cmd.avail  = LINE_CODING_LEN;
					cmd.asked  = LEN_NO_LIMIT;
					class_done = 1'b1;
				end else if (req.request_code == REQ_CDC_GET_LINE_CODING) begin
					cmd.action = ACT_REPLY;
					cmd.source = SRC_LINE_CODING;
					cmd.avail  = LINE_CODING_LEN;
					cmd.asked  = req.request_length;
					class_done = 1'b1;
				end
			end else if (cfg.device_class == CLASS_MSC) begin
				if (req.request_code == REQ_MSC_GET_MAX_LUN && to_host) begin
					cmd.action = ACT_REPLY;
					cmd.source = SRC_INLINE;
					cmd.avail  = 16'd1;
					cmd.asked  = req.request_length;
					class_done = 1'b1;
				end else if (req.request_code == REQ_MSC_BULK_ONLY_RESET && !to_host) begin
					cmd.effects[FX_CLASS_RESET] = 1'b1;
					cmd.action                  = ACT_STATUS;
					class_done                  = 1'b1;
				end
			end
			// Any class request not handled by name: a no-data OUT request is
			// acknowledged, everything else stalls.
			if (!class_done) begin
				cmd.action = (!to_host && req.request_length == 16'd0) ? ACT_STATUS : ACT_STALL;
			end
		end else if (req_kind == TYPE_STANDARD) begin
			case (req.request_code)
				REQ_SET_ADDRESS: begin
					cmd.device_address      = req.request_value[6:0];
					cmd.effects[FX_ADDRESS] = 1'b1;
					cmd.action              = ACT_STATUS;
				end
				REQ_GET_DESCRIPTOR: begin
					cmd.asked = req.request_length;
					if (desc_type == DTYPE_DEVICE) begin
						cmd.action = ACT_REPLY;
						cmd.source = SRC_DEVICE;
						cmd.avail  = DEVICE_DESC_LEN;
					end else if (desc_type == DTYPE_CONFIG) begin
						cmd.action = ACT_REPLY;
						cmd.source = SRC_CONFIG;
						cmd.avail  = cfg.config_length;
					end else if (desc_type == DTYPE_STRING && desc_index[7:2] == 6'd0 &&
						cfg.string_valid_mask[desc_index[1:0]]) begin
						cmd.action = ACT_REPLY;
						cmd.source = SRC_STRING0 + {1'b0, desc_index[1:0]};
						cmd.avail  = {8'd0, cfg.str_bytes[desc_index[1:0]]};
					end
				end
				REQ_SET_CONFIGURATION: begin
					cmd.configuration      = req.request_value[7:0];
					cmd.effects[FX_CONFIG] = 1'b1;
					cmd.action             = ACT_STATUS;
				end
				REQ_GET_CONFIGURATION: begin
					cmd.byte_zero_from_conf = 1'b1;
					cmd.action              = ACT_REPLY;
					cmd.source              = SRC_INLINE;
					cmd.avail               = 16'd1;
					cmd.asked               = req.request_length;
				end
				REQ_GET_STATUS: begin
					cmd.byte_zero = {7'd0, recipient == RCPT_DEVICE && cfg.self_pwr};
					cmd.action    = ACT_REPLY;
					cmd.source    = SRC_INLINE;
					cmd.avail     = 16'd2;
					cmd.asked     = req.request_length;
				end
				REQ_GET_INTERFACE: begin
					cmd.action = ACT_REPLY;
					cmd.source = SRC_INLINE;
					cmd.avail  = 16'd1;
					cmd.asked  = req.request_length;
				end
				REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
					// Only the endpoint halt feature has an effect.
					if (recipient == RCPT_ENDPOINT && req.request_value == 16'd0) begin
						cmd.endpoint = req.request_index[7:0];
						if (req.request_code == REQ_CLEAR_FEATURE) begin
							cmd.effects[FX_UNHALT] = 1'b1;
						end else begin
							cmd.effects[FX_HALT] = 1'b1;
						end
					end
					cmd.action = ACT_STATUS;
				end
				REQ_SET_INTERFACE: begin
					cmd.action = ACT_STATUS;
				end
				default: begin
					cmd.action = ACT_STALL;
				end
			endcase
		end
	end

endmodule

// ----- design/usrd_cmd_fifo.sv -----
// Short command queue between the classifying front end and the executing back end.
// Depends on usrd_pkg for the command type and the queue depth.
module usrd_cmd_fifo
	import usrd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cmd_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- design/usrd_back.sv -----
// Back end: carries out queued commands, keeps the current configuration, and holds
// the result register. Depends on usrd_pkg and usrd_result_if.
module usrd_back
	import usrd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic pop,
	usrd_result_if.source rsp
);

	logic        valid_q;
	logic [7:0]  cur_conf_q;
	action_t     action_q;
	logic [2:0]  source_q;
	logic [15:0] length_q;
	logic [7:0]  byte_zero_q;
	logic [FX_WIDTH-1:0] effects_q;
	logic [6:0]  address_q;
	logic [7:0]  conf_q;
	logic        dtr_q;
	logic [7:0]  endpoint_q;

	assign pop = cmd_valid && (!valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			cur_conf_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (cmd.effects[FX_CONFIG]) begin
					cur_conf_q <= cmd.configuration;
				end
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			action_q    <= cmd.action;
			source_q    <= cmd.source;
			length_q    <= (cmd.avail < cmd.asked) ? cmd.avail : cmd.asked;
			byte_zero_q <= cmd.byte_zero_from_conf ? cur_conf_q : cmd.byte_zero;
			effects_q   <= cmd.effects;
			address_q   <= cmd.device_address;
			conf_q      <= cmd.configuration;
			dtr_q       <= cmd.dtr;
			endpoint_q  <= cmd.endpoint;
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.action          = action_q;
	assign rsp.reply_source    = source_q;
	assign rsp.reply_length    = length_q;
	assign rsp.reply_byte_zero = byte_zero_q;
	assign rsp.reply_byte_one  = 8'd0;
	assign rsp.effects         = effects_q;
	assign rsp.device_address  = address_q;
	assign rsp.configuration   = conf_q;
	assign rsp.dtr             = dtr_q;
	assign rsp.endpoint        = endpoint_q;

endmodule

// ----- design/usb_setup_request_decoder.sv -----
// Top level of the USB setup request decoder: configuration registers, front end,
// command queue and back end. Depends on usrd_pkg, usrd_if and the usrd_* modules.
//
// The block takes one decoded SETUP packet per transaction on the req channel and
// returns one decision per packet on the rsp channel: stall, status only, reply data
// (with its source and its length, the smaller of what is available and what the host
// asked for) or accept seven OUT bytes, together with the side effects the device
// must apply (new address, new configuration, line state, class reset, endpoint halt).
// Both channels use valid/ready; a transaction completes when both are high.
//
// The front end classifies a packet in the cycle it is accepted and writes the
// command into a two-entry queue. The back end takes it from the queue when the output
// register is empty or being taken, applies the configuration state and loads the
// output register. One packet per cycle is sustained while rsp.ready stays high; the
// queue absorbs stalls so that req.ready stays high while a result waits on the rsp
// side. When both the queue and the output register are full, req.ready drops until
// the receiver takes a result.
//
// Configuration registers are written through cfg_we/cfg_index/cfg_data and are only
// to be written while no transaction is in flight. Reset clears the configuration
// registers, the stored configuration value, the queue and the output valid.
module usb_setup_request_decoder
	import usrd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	usrd_setup_if.sink             req,
	usrd_result_if.source          rsp
);

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_not_empty;

	// Configuration register file; each register keeps only its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_CLASS:  cfg_q.device_class      <= cfg_data[1:0];
				CFG_SELF_PWR:      cfg_q.self_pwr          <= cfg_data[0];
				CFG_CONFIG_LENGTH: cfg_q.config_length     <= cfg_data;
				CFG_STRING_MASK:   cfg_q.string_valid_mask <= cfg_data[NUM_STRINGS-1:0];
				CFG_STRING0_LEN:   cfg_q.str_bytes[0]      <= cfg_data[7:0];
				CFG_STRING1_LEN:   cfg_q.str_bytes[1]      <= cfg_data[7:0];
				CFG_STRING2_LEN:   cfg_q.str_bytes[2]      <= cfg_data[7:0];
				CFG_STRING3_LEN:   cfg_q.str_bytes[3]      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	usrd_front u_front (
		.cfg  (cfg_q),
		.req  (req),
		.full (queue_full),
		.push (push),
		.cmd  (front_cmd)
	);

	usrd_cmd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.pop_data  (queue_cmd)
	);

	usrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_not_empty),
		.cmd       (queue_cmd),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule
